[hw/rtl/egag_pkg.sv]
// Package for the evidence-gated authority governor.
// Shared widths, register indexes and the structs passed between the front
// end, the queue and the back end. No dependencies.
package egag_pkg;

    localparam int COUNT_BITS = 8;
    localparam int EPOCH_BITS = 32;
    localparam int FRAC_BITS  = 12;
    localparam int FIX_BITS   = FRAC_BITS + 1;
    localparam int LVL_BITS   = 2;
    localparam int DWELL_BITS = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [FIX_BITS-1:0]   FIX_ONE   = FIX_BITS'(1) << FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LVL3_MAX_RISK  = 3'd0,
        REG_LVL2_MAX_RISK  = 3'd1,
        REG_LVL1_MAX_RISK  = 3'd2,
        REG_LVL3_MIN_AGREE = 3'd3,
        REG_LVL2_MIN_AGREE = 3'd4,
        REG_LVL1_MIN_AGREE = 3'd5,
        REG_DWELL_NEEDED   = 3'd6,
        REG_LEVEL_CEILING  = 3'd7
    } cfg_idx_t;

    // Item function codes
    localparam logic FUNC_EVIDENCE = 1'b0;
    localparam logic FUNC_INIT     = 1'b1;

    typedef struct packed {
        logic [FIX_BITS-1:0]   lvl3_max_risk;
        logic [FIX_BITS-1:0]   lvl2_max_risk;
        logic [FIX_BITS-1:0]   lvl1_max_risk;
        logic [FIX_BITS-1:0]   lvl3_min_agree;
        logic [FIX_BITS-1:0]   lvl2_min_agree;
        logic [FIX_BITS-1:0]   lvl1_min_agree;
        logic [DWELL_BITS-1:0] dwell_needed;
        logic [LVL_BITS-1:0]   level_ceiling;
    } cfg_t;

    // Classified item handed from front end to back end
    typedef struct packed {
        logic                  func;
        logic [LVL_BITS-1:0]   start_level;
        logic                  usable;
        logic [LVL_BITS-1:0]   goal;
        logic [EPOCH_BITS-1:0] epoch;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic [LVL_BITS-1:0]   prior_level;
        logic [LVL_BITS-1:0]   goal_level;
        logic [LVL_BITS-1:0]   new_level;
        logic [COUNT_BITS-1:0] dwell_count;
        logic                  was_demoted;
        logic                  was_promoted;
        logic                  was_counted;
        logic                  was_rejected;
    } result_t;

    // Queue status: full toward the producer side, empty toward the back end
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hw/rtl/egag_front.sv]
// Front end of the authority governor: checks evidence and grades it into
// a goal level against the live thresholds. Depends on egag_pkg.
module egag_front (
    input  egag_pkg::cfg_t                   cfg,
    input  logic                             func,
    input  logic [egag_pkg::LVL_BITS-1:0]    start_level,
    input  logic [egag_pkg::FIX_BITS-1:0]    risk_bound,
    input  logic [egag_pkg::FIX_BITS-1:0]    agreement,
    input  logic                             is_fresh,
    input  logic                             provenance_ok,
    input  logic                             witness_ok,
    input  logic                             anchor_ok,
    input  logic [egag_pkg::EPOCH_BITS-1:0]  epoch,
    output egag_pkg::item_t                  item
);

    logic                          usable;
    logic [egag_pkg::LVL_BITS-1:0] raw_goal;
    logic [egag_pkg::LVL_BITS-1:0] capped_start;

    // Evidence is usable only with all flags set and both values in [0, 1.0]
    assign usable = is_fresh && provenance_ok && witness_ok && anchor_ok
                    && (risk_bound <= egag_pkg::FIX_ONE)
                    && (agreement <= egag_pkg::FIX_ONE);

    // Graded thresholds, highest level wins
    always_comb
    begin
        raw_goal = '0;
        if (usable)
        begin
            priority if (risk_bound <= cfg.lvl3_max_risk && agreement >= cfg.lvl3_min_agree)
                raw_goal = 2'd3;
            else if (risk_bound <= cfg.lvl2_max_risk && agreement >= cfg.lvl2_min_agree)
                raw_goal = 2'd2;
            else if (risk_bound <= cfg.lvl1_max_risk && agreement >= cfg.lvl1_min_agree)
                raw_goal = 2'd1;
            else
                raw_goal = 2'd0;
        end
    end

    assign capped_start = (start_level < cfg.level_ceiling) ? start_level : cfg.level_ceiling;

    // Pack the classified transaction
    always_comb
    begin
        item.func        = func;
        item.start_level = capped_start;
        item.usable      = usable;
        item.goal        = (raw_goal < cfg.level_ceiling) ? raw_goal : cfg.level_ceiling;
        item.epoch       = epoch;
    end

endmodule

[hw/rtl/egag_queue.sv]
// Two-entry queue between governor front end and back end.
// Holds classified items so either side can stall alone. Depends on egag_pkg.
module egag_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  egag_pkg::item_t      push_item,
    input  logic                 pop,
    output egag_pkg::item_t      head_item,
    output egag_pkg::q_status_t  status
);

    localparam int PTR_BITS = $clog2(egag_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(egag_pkg::QUEUE_DEPTH + 1);

    egag_pkg::item_t       mem [egag_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    assign status.full  = (count_reg == CNT_BITS'(egag_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_item    = mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(egag_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + PTR_BITS'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(egag_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + PTR_BITS'(1);
        if (push && !pop)
            count_next = count_reg + CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

[hw/rtl/egag_back.sv]
// Back end of the authority governor: holds level, dwell counter, last
// epoch and init flag, and registers one result per item. Depends on egag_pkg.
module egag_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  egag_pkg::cfg_t       cfg,
    input  logic                 item_valid,
    input  egag_pkg::item_t      item,
    output logic                 item_pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output egag_pkg::result_t    res
);

    logic [egag_pkg::LVL_BITS-1:0]   level_reg, level_next;
    logic [egag_pkg::COUNT_BITS-1:0] dwell_reg, dwell_next;
    logic [egag_pkg::EPOCH_BITS-1:0] last_epoch_reg, last_epoch_next;
    logic                            ready_reg, ready_next;
    logic                            res_valid_reg;
    egag_pkg::result_t               res_reg, res_next;

    logic                            newer;
    logic [egag_pkg::COUNT_BITS-1:0] dwell_inc;
    logic [egag_pkg::COUNT_BITS-1:0] dwell_eff;
    logic [egag_pkg::LVL_BITS-1:0]   lvl_tmp;

    // Take an item whenever the output register is free or draining
    assign item_pop  = item_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign newer     = item.epoch > last_epoch_reg;
    assign dwell_inc = (dwell_reg == egag_pkg::COUNT_MAX) ? dwell_reg
                       : dwell_reg + egag_pkg::COUNT_BITS'(1);
    assign dwell_eff = (cfg.dwell_needed == '0) ? egag_pkg::COUNT_BITS'(1)
                       : egag_pkg::COUNT_BITS'(cfg.dwell_needed);

    // State update and result for one transaction
    always_comb
    begin
        level_next      = level_reg;
        dwell_next      = dwell_reg;
        last_epoch_next = last_epoch_reg;
        ready_next      = ready_reg;
        lvl_tmp         = level_reg;
        res_next        = '0;
        res_next.prior_level = level_reg;

        if (item.func == egag_pkg::FUNC_INIT)
        begin
            level_next      = item.start_level;
            dwell_next      = '0;
            last_epoch_next = item.epoch;
            ready_next      = 1'b1;
            res_next.new_level = item.start_level;
        end
        else if (!ready_reg)
        begin
            res_next.prior_level  = '0;
            res_next.was_rejected = 1'b1;
        end
        else
        begin
            res_next.goal_level   = item.goal;
            res_next.was_rejected = !item.usable;
            if (item.goal < level_reg)
            begin
                lvl_tmp    = item.goal;
                dwell_next = '0;
                res_next.was_demoted = 1'b1;
            end
            else if (item.goal == level_reg)
            begin
                dwell_next = '0;
            end
            else if (item.usable && newer)
            begin
                dwell_next = dwell_inc;
                res_next.was_counted = 1'b1;
                if (dwell_inc >= dwell_eff)
                begin
                    lvl_tmp    = level_reg + egag_pkg::LVL_BITS'(1);
                    dwell_next = '0;
                    res_next.was_promoted = 1'b1;
                end
            end
            if (item.usable && newer)
                last_epoch_next = item.epoch;
            level_next = (lvl_tmp < cfg.level_ceiling) ? lvl_tmp : cfg.level_ceiling;
            res_next.new_level = level_next;
        end
        res_next.dwell_count = dwell_next;
    end

    // Governor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            dwell_reg      <= '0;
            last_epoch_reg <= '0;
            ready_reg      <= 1'b0;
        end
        else if (item_pop)
        begin
            level_reg      <= level_next;
            dwell_reg      <= dwell_next;
            last_epoch_reg <= last_epoch_next;
            ready_reg      <= ready_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (item_pop)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (item_pop)
            res_reg <= res_next;
    end

endmodule

[hw/rtl/evidence_gated_authority_governor_core.sv]
// Top level of the evidence-gated authority governor.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on egag_pkg, egag_front, egag_queue and egag_back.

// The governor takes one item per clock while in_stall is low and gives one
// result per item, in order. The item is classified in the cycle it is
// offered and written into the two-entry queue when accepted; the back end
// then pops it from the queue, updates the level, dwell counter and last
// epoch and fills the output register. The sustained rate, one item per
// cycle, is set by the state update in the back end and holds while
// out_stall lets the output register drain. in_stall rises only
// when the queue is full. Configuration registers are always ready and are
// read live; write them only while no transaction is in flight.
module evidence_gated_authority_governor_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [egag_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [egag_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  func,
    input  logic [egag_pkg::LVL_BITS-1:0]         start_level,
    input  logic [egag_pkg::FIX_BITS-1:0]         risk_bound,
    input  logic [egag_pkg::FIX_BITS-1:0]         agreement,
    input  logic                                  is_fresh,
    input  logic                                  provenance_ok,
    input  logic                                  witness_ok,
    input  logic                                  anchor_ok,
    input  logic [egag_pkg::EPOCH_BITS-1:0]       epoch,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [egag_pkg::LVL_BITS-1:0]         prior_level,
    output logic [egag_pkg::LVL_BITS-1:0]         goal_level,
    output logic [egag_pkg::LVL_BITS-1:0]         new_level,
    output logic [egag_pkg::COUNT_BITS-1:0]       dwell_count,
    output logic                                  was_demoted,
    output logic                                  was_promoted,
    output logic                                  was_counted,
    output logic                                  was_rejected
);

    egag_pkg::cfg_t       cfg_reg;
    egag_pkg::item_t      front_item;
    egag_pkg::item_t      head_item;
    egag_pkg::q_status_t  q_stat;
    egag_pkg::result_t    res;
    logic                 push;
    logic                 pop;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lvl3_max_risk  <= egag_pkg::FIX_BITS'(1229);
            cfg_reg.lvl2_max_risk  <= egag_pkg::FIX_BITS'(2253);
            cfg_reg.lvl1_max_risk  <= egag_pkg::FIX_BITS'(3277);
            cfg_reg.lvl3_min_agree <= egag_pkg::FIX_BITS'(3277);
            cfg_reg.lvl2_min_agree <= egag_pkg::FIX_BITS'(2458);
            cfg_reg.lvl1_min_agree <= egag_pkg::FIX_BITS'(1434);
            cfg_reg.dwell_needed   <= egag_pkg::DWELL_BITS'(8);
            cfg_reg.level_ceiling  <= egag_pkg::LVL_BITS'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (egag_pkg::cfg_idx_t'(cfg_index))
                egag_pkg::REG_LVL3_MAX_RISK:
                    cfg_reg.lvl3_max_risk  <= egag_pkg::FIX_BITS'(cfg_data);
                egag_pkg::REG_LVL2_MAX_RISK:
                    cfg_reg.lvl2_max_risk  <= egag_pkg::FIX_BITS'(cfg_data);
                egag_pkg::REG_LVL1_MAX_RISK:
                    cfg_reg.lvl1_max_risk  <= egag_pkg::FIX_BITS'(cfg_data);
                egag_pkg::REG_LVL3_MIN_AGREE:
                    cfg_reg.lvl3_min_agree <= egag_pkg::FIX_BITS'(cfg_data);
                egag_pkg::REG_LVL2_MIN_AGREE:
                    cfg_reg.lvl2_min_agree <= egag_pkg::FIX_BITS'(cfg_data);
                egag_pkg::REG_LVL1_MIN_AGREE:
                    cfg_reg.lvl1_min_agree <= egag_pkg::FIX_BITS'(cfg_data);
                egag_pkg::REG_DWELL_NEEDED:
                    cfg_reg.dwell_needed   <= cfg_data[egag_pkg::DWELL_BITS-1:0];
                egag_pkg::REG_LEVEL_CEILING:
                    cfg_reg.level_ceiling  <= cfg_data[egag_pkg::LVL_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end: classify the incoming transaction
    egag_front u_front (
        .cfg           (cfg_reg),
        .func          (func),
        .start_level   (start_level),
        .risk_bound    (risk_bound),
        .agreement     (agreement),
        .is_fresh      (is_fresh),
        .provenance_ok (provenance_ok),
        .witness_ok    (witness_ok),
        .anchor_ok     (anchor_ok),
        .epoch         (epoch),
        .item          (front_item)
    );

    assign in_stall = q_stat.full;
    assign push     = in_valid && !in_stall;

    // Decoupling queue
    egag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_stat)
    );

    // Back end: state update and result register
    egag_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (!q_stat.empty),
        .item       (head_item),
        .item_pop   (pop),
        .res_valid  (out_valid),
        .res_stall  (out_stall),
        .res        (res)
    );

    assign prior_level  = res.prior_level;
    assign goal_level   = res.goal_level;
    assign new_level    = res.new_level;
    assign dwell_count  = res.dwell_count;
    assign was_demoted  = res.was_demoted;
    assign was_promoted = res.was_promoted;
    assign was_counted  = res.was_counted;
    assign was_rejected = res.was_rejected;

`ifndef SYNTHESIS
    // A result never both promotes and demotes
    a_prom_dem_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_promoted && was_demoted))
        else $error("promotion and demotion in one result");

    // Promotion raises the level by exactly one
    a_prom_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_promoted) |-> (new_level == prior_level + 2'd1))
        else $error("promotion did not step one level");

    // Demotion lowers the level
    a_dem_lower: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_demoted) |-> (new_level < prior_level))
        else $error("demotion did not lower the level");

    // A full queue means the back end was holding on the previous cycle
    a_full_held: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_stat.full) |-> $past(!pop))
        else $error("queue filled while back end was draining");
`endif

endmodule

[dv/evidence_gated_authority_governor_core_tb.sv]
// Self-checking testbench for evidence_gated_authority_governor_core.
// Depends on egag_pkg and the governor RTL only; keeps its own predictor of
// level, dwell counter, last epoch and register copies to check every result.
module evidence_gated_authority_governor_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 4;
    localparam logic [3:0]  ALL_FLAGS    = 4'hF;

    localparam logic [egag_pkg::CFG_DATA_BITS-1:0] REG_DEFAULTS [8] =
        '{13'd1229, 13'd2253, 13'd3277, 13'd3277, 13'd2458, 13'd1434, 13'd8, 13'd3};

    // One input transaction as driven on the ports
    typedef struct packed {
        logic                            func;
        logic [egag_pkg::LVL_BITS-1:0]   start_level;
        logic [egag_pkg::FIX_BITS-1:0]   risk;
        logic [egag_pkg::FIX_BITS-1:0]   agree;
        logic                            fresh;
        logic                            prov;
        logic                            wit;
        logic                            anc;
        logic [egag_pkg::EPOCH_BITS-1:0] epoch;
    } evidence_item_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [egag_pkg::CFG_IDX_BITS-1:0]    cfg_index;
    logic [egag_pkg::CFG_DATA_BITS-1:0]   cfg_data;
    logic                                 in_valid;
    logic                                 in_stall;
    logic                                 func;
    logic [egag_pkg::LVL_BITS-1:0]        start_level;
    logic [egag_pkg::FIX_BITS-1:0]        risk_bound;
    logic [egag_pkg::FIX_BITS-1:0]        agreement;
    logic                                 is_fresh;
    logic                                 provenance_ok;
    logic                                 witness_ok;
    logic                                 anchor_ok;
    logic [egag_pkg::EPOCH_BITS-1:0]      epoch;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [egag_pkg::LVL_BITS-1:0]        prior_level;
    logic [egag_pkg::LVL_BITS-1:0]        goal_level;
    logic [egag_pkg::LVL_BITS-1:0]        new_level;
    logic [egag_pkg::COUNT_BITS-1:0]      dwell_count;
    logic                                 was_demoted;
    logic                                 was_promoted;
    logic                                 was_counted;
    logic                                 was_rejected;

    // Predictor state and register copies
    logic [egag_pkg::CFG_DATA_BITS-1:0]   reg_shadow [8];
    logic [egag_pkg::LVL_BITS-1:0]        auth_level;
    logic [egag_pkg::COUNT_BITS-1:0]      dwell_ctr;
    logic [egag_pkg::EPOCH_BITS-1:0]      last_ep;
    logic                                 governor_ready;

    egag_pkg::result_t                    pending_results [$];
    int                                   errors = 0;
    int unsigned                          cycle_count = 0;

    // Sender and receiver pacing knobs
    int                                   gap_max = 0;
    int                                   burst_left = 0;
    stall_mode_t                          stall_mode = STALL_NONE;
    int                                   hold_request = 0;
    int                                   hold_left = 0;
    int unsigned                          stall_phase = 0;

    evidence_gated_authority_governor_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .start_level   (start_level),
        .risk_bound    (risk_bound),
        .agreement     (agreement),
        .is_fresh      (is_fresh),
        .provenance_ok (provenance_ok),
        .witness_ok    (witness_ok),
        .anchor_ok     (anchor_ok),
        .epoch         (epoch),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .prior_level   (prior_level),
        .goal_level    (goal_level),
        .new_level     (new_level),
        .dwell_count   (dwell_count),
        .was_demoted   (was_demoted),
        .was_promoted  (was_promoted),
        .was_counted   (was_counted),
        .was_rejected  (was_rejected)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: long hold-off on request, otherwise a stall pattern per mode
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            case (stall_mode)
                STALL_LIGHT:   out_stall <= ($urandom_range(0, 2) == 0);
                STALL_PATTERN: out_stall <= (stall_phase % 7 == 0) || (stall_phase % 7 == 4)
                                            || (stall_phase % 7 == 5);
                STALL_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
                default:       out_stall <= 1'b0;
            endcase
        end
        stall_phase++;
    end

    // Authority governor prediction for one accepted transaction
    function automatic egag_pkg::result_t govern_step(input evidence_item_t s);
        egag_pkg::result_t             r;
        logic                          ok;
        logic                          newer;
        logic [egag_pkg::LVL_BITS-1:0] g;
        logic [egag_pkg::LVL_BITS-1:0] ceil_lvl;
        logic [7:0]                    need;
        r        = '0;
        ceil_lvl = reg_shadow[egag_pkg::REG_LEVEL_CEILING][egag_pkg::LVL_BITS-1:0];
        need     = reg_shadow[egag_pkg::REG_DWELL_NEEDED][7:0];
        if (need == 8'd0)
            need = 8'd1;
        r.prior_level = auth_level;
        if (s.func == egag_pkg::FUNC_INIT)
        begin
            auth_level     = (s.start_level > ceil_lvl) ? ceil_lvl : s.start_level;
            dwell_ctr      = '0;
            last_ep        = s.epoch;
            governor_ready = 1'b1;
            r.new_level    = auth_level;
            return r;
        end
        if (!governor_ready)
        begin
            r.prior_level  = '0;
            r.was_rejected = 1'b1;
            return r;
        end
        ok    = s.fresh && s.prov && s.wit && s.anc && (s.risk <= egag_pkg::FIX_ONE)
                && (s.agree <= egag_pkg::FIX_ONE);
        newer = s.epoch > last_ep;
        g     = '0;
        // Graded thresholds, highest passing level wins
        if (ok)
        begin
            if (s.risk <= reg_shadow[egag_pkg::REG_LVL1_MAX_RISK]
                && s.agree >= reg_shadow[egag_pkg::REG_LVL1_MIN_AGREE])
                g = 2'd1;
            if (s.risk <= reg_shadow[egag_pkg::REG_LVL2_MAX_RISK]
                && s.agree >= reg_shadow[egag_pkg::REG_LVL2_MIN_AGREE])
                g = 2'd2;
            if (s.risk <= reg_shadow[egag_pkg::REG_LVL3_MAX_RISK]
                && s.agree >= reg_shadow[egag_pkg::REG_LVL3_MIN_AGREE])
                g = 2'd3;
            if (g > ceil_lvl)
                g = ceil_lvl;
        end
        // Demote at once, promote one step after enough newer evidence
        if (g < auth_level)
        begin
            auth_level    = g;
            dwell_ctr     = '0;
            r.was_demoted = 1'b1;
        end
        else if (g == auth_level)
            dwell_ctr = '0;
        else if (ok && newer)
        begin
            if (dwell_ctr != egag_pkg::COUNT_MAX)
                dwell_ctr++;
            r.was_counted = 1'b1;
            if (dwell_ctr >= need)
            begin
                auth_level     = auth_level + 2'd1;
                dwell_ctr      = '0;
                r.was_promoted = 1'b1;
            end
        end
        if (ok && newer)
            last_ep = s.epoch;
        if (auth_level > ceil_lvl)
            auth_level = ceil_lvl;
        r.goal_level   = g;
        r.new_level    = auth_level;
        r.dwell_count  = dwell_ctr;
        r.was_rejected = !ok;
        return r;
    endfunction

    function automatic logic [egag_pkg::FIX_BITS-1:0] cap_one(
        input logic [egag_pkg::FIX_BITS-1:0] v);
        return (v > egag_pkg::FIX_ONE) ? egag_pkg::FIX_ONE : v;
    endfunction

    function automatic evidence_item_t evidence(input logic [egag_pkg::FIX_BITS-1:0] r_code,
                                                input logic [egag_pkg::FIX_BITS-1:0] a_code,
                                                input logic [3:0] flags,
                                                input logic [egag_pkg::EPOCH_BITS-1:0] ep);
        evidence_item_t s;
        s             = '0;
        s.func        = egag_pkg::FUNC_EVIDENCE;
        s.start_level = egag_pkg::LVL_BITS'($urandom);
        s.risk        = r_code;
        s.agree       = a_code;
        {s.fresh, s.prov, s.wit, s.anc} = flags;
        s.epoch       = ep;
        return s;
    endfunction

    function automatic evidence_item_t init_item(input logic [egag_pkg::LVL_BITS-1:0] lvl,
                                                 input logic [egag_pkg::EPOCH_BITS-1:0] ep);
        evidence_item_t s;
        s             = evidence_item_t'({$urandom, $urandom});
        s.func        = egag_pkg::FUNC_INIT;
        s.start_level = lvl;
        s.epoch       = ep;
        return s;
    endfunction

    // Fully random evidence, mostly unusable
    function automatic evidence_item_t noise_item();
        evidence_item_t s;
        s      = evidence_item_t'({$urandom, $urandom});
        s.func = egag_pkg::FUNC_EVIDENCE;
        return s;
    endfunction

    // Codes at and around the thresholds and the 1.0 boundary
    function automatic logic [egag_pkg::FIX_BITS-1:0] near_code(
        input logic [egag_pkg::FIX_BITS-1:0] thr);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return egag_pkg::FIX_ONE;
            2:       return thr;
            3:       return (thr != 0) ? thr - 1'b1 : thr;
            4:       return (thr != '1) ? thr + 1'b1 : thr;
            default: return egag_pkg::FIX_BITS'($urandom_range(0, 4096));
        endcase
    endfunction

    // Epoch mostly newer than the last accepted one
    function automatic logic [egag_pkg::EPOCH_BITS-1:0] pick_epoch();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return (last_ep > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF : last_ep + $urandom_range(1, 4);
        else if (r < 85)
            return last_ep;
        else if (r < 93)
            return (last_ep >= 4) ? last_ep - $urandom_range(1, 3) : '0;
        return $urandom;
    endfunction

    function automatic evidence_item_t well_formed(input int strong_pct);
        logic [egag_pkg::FIX_BITS-1:0] r_code;
        logic [egag_pkg::FIX_BITS-1:0] a_code;
        logic [3:0]                    flags;
        egag_pkg::cfg_idx_t            r_idx;
        if ($urandom_range(1, 100) <= strong_pct)
        begin
            r_code = egag_pkg::FIX_BITS'($urandom_range(0,
                         cap_one(reg_shadow[egag_pkg::REG_LVL3_MAX_RISK])));
            a_code = egag_pkg::FIX_BITS'($urandom_range(
                         cap_one(reg_shadow[egag_pkg::REG_LVL3_MIN_AGREE]), 4096));
        end
        else
        begin
            r_idx  = egag_pkg::cfg_idx_t'($urandom_range(0, 2));
            r_code = near_code(reg_shadow[r_idx]);
            a_code = near_code(reg_shadow[r_idx + 3]);
        end
        flags = ($urandom_range(0, 9) == 0) ? 4'($urandom) : ALL_FLAGS;
        return evidence(r_code, a_code, flags, pick_epoch());
    endfunction

    // Offer one transaction; sender bursts are separated by random gaps
    task automatic send_item(input evidence_item_t s);
        int gap;
        @(negedge clk);
        if (gap_max > 0 && burst_left == 0)
        begin
            gap = $urandom_range(1, gap_max);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        func          <= s.func;
        start_level   <= s.start_level;
        risk_bound    <= s.risk;
        agreement     <= s.agree;
        is_fresh      <= s.fresh;
        provenance_ok <= s.prov;
        witness_ok    <= s.wit;
        anchor_ok     <= s.anc;
        epoch         <= s.epoch;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(govern_step(s));
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input egag_pkg::cfg_idx_t idx,
                             input logic [egag_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            egag_pkg::REG_DWELL_NEEDED:  reg_shadow[idx] = val & 13'h00FF;
            egag_pkg::REG_LEVEL_CEILING: reg_shadow[idx] = val & 13'h0003;
            default:                     reg_shadow[idx] = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result checker: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        egag_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no prediction pending");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("prior_level", 32'(want.prior_level), 32'(prior_level));
                check_field("goal_level", 32'(want.goal_level), 32'(goal_level));
                check_field("new_level", 32'(want.new_level), 32'(new_level));
                check_field("dwell_count", 32'(want.dwell_count), 32'(dwell_count));
                check_field("was_demoted", 32'(want.was_demoted), 32'(was_demoted));
                check_field("was_promoted", 32'(want.was_promoted), 32'(was_promoted));
                check_field("was_counted", 32'(want.was_counted), 32'(was_counted));
                check_field("was_rejected", 32'(want.was_rejected), 32'(was_rejected));
            end
        end
    end

    // Evidence before any initialize is rejected with default fields
    task automatic test_before_init();
        send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'd1));
        send_item(evidence(13'h1FFF, 13'h1FFF, 4'h0, 32'hFFFF_FFFF));
        send_item(evidence(13'd4097, 13'd0, ALL_FLAGS, 32'd5));
        send_item(noise_item());
        drain();
    endtask

    // Field extremes, each flag, boundaries, stale and equal epochs
    task automatic test_directed();
        send_item(init_item(2'd3, 32'd100));
        send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'd101));      // goal equals level
        send_item(evidence(13'd4097, 13'd4096, ALL_FLAGS, 32'd102));   // unusable, demote to 0
        send_item(evidence(13'd0, 13'd4097, ALL_FLAGS, 32'd103));
        send_item(evidence(13'd0, 13'd4096, 4'b0111, 32'd104));
        send_item(evidence(13'd0, 13'd4096, 4'b1011, 32'd105));
        send_item(evidence(13'd0, 13'd4096, 4'b1101, 32'd106));
        send_item(evidence(13'd0, 13'd4096, 4'b1110, 32'd107));
        send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'd108));      // counted
        send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'd108));      // same epoch
        send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'd50));       // stale
        send_item(evidence(13'd1229, 13'd3277, ALL_FLAGS, 32'd109));   // at the level 3 thresholds
        send_item(evidence(13'd1230, 13'd3277, ALL_FLAGS, 32'd110));
        send_item(evidence(13'd2253, 13'd2458, ALL_FLAGS, 32'd111));
        send_item(evidence(13'd3277, 13'd1434, ALL_FLAGS, 32'd112));
        send_item(evidence(13'd3278, 13'd1433, ALL_FLAGS, 32'd113));   // goal 0, count clears
        send_item(evidence(13'd4096, 13'd0, ALL_FLAGS, 32'd114));
        send_item(evidence(13'h1FFF, 13'h1FFF, ALL_FLAGS, 32'd115));
        send_item(init_item(2'd2, 32'hFFFF_FFFE));
        send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'hFFFF_FFFF));
        send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'hFFFF_FFFF));
        send_item(init_item(2'd0, 32'd0));
        send_item(evidence(13'd0, 13'd0, ALL_FLAGS, 32'd0));
        drain();
    endtask

    // Register extremes: dwell zero, lowered ceiling, threshold corners, dwell 255
    task automatic test_config_edges();
        int i;
        write_reg(egag_pkg::REG_DWELL_NEEDED, 13'd0);
        send_item(init_item(2'd0, 32'd10));
        for (i = 0; i < 4; i++)
            send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'd11 + i));
        drain();
        // level above a lowered ceiling demotes on the next evidence
        write_reg(egag_pkg::REG_LEVEL_CEILING, 13'd1);
        send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'd20));
        drain();
        write_reg(egag_pkg::REG_LEVEL_CEILING, 13'd0);
        send_item(init_item(2'd3, 32'd30));
        send_item(evidence(13'd0, 13'd4096, ALL_FLAGS, 32'd31));
        drain();
        write_reg(egag_pkg::REG_LEVEL_CEILING, 13'h1FFE);
        write_reg(egag_pkg::REG_DWELL_NEEDED, 13'h1F02);
        write_reg(egag_pkg::REG_LVL3_MAX_RISK, 13'd0);
        write_reg(egag_pkg::REG_LVL2_MAX_RISK, 13'd0);
        write_reg(egag_pkg::REG_LVL1_MAX_RISK, 13'd0);
        write_reg(egag_pkg::REG_LVL3_MIN_AGREE, 13'd0);
        write_reg(egag_pkg::REG_LVL2_MIN_AGREE, 13'd0);
        write_reg(egag_pkg::REG_LVL1_MIN_AGREE, 13'd0);
        send_item(evidence(13'd0, 13'd0, ALL_FLAGS, 32'd40));
        send_item(evidence(13'd1, 13'd0, ALL_FLAGS, 32'd41));
        send_item(evidence(13'd0, 13'd0, ALL_FLAGS, 32'd42));
        send_item(evidence(13'd0, 13'd0, ALL_FLAGS, 32'd43));
        drain();
        write_reg(egag_pkg::REG_LVL3_MAX_RISK, 13'h1FFF);
        write_reg(egag_pkg::REG_LVL3_MIN_AGREE, 13'h1FFF);
        write_reg(egag_pkg::REG_LVL2_MAX_RISK, 13'd4096);
        write_reg(egag_pkg::REG_LVL2_MIN_AGREE, 13'd4096);
        send_item(evidence(13'd4096, 13'd4096, ALL_FLAGS, 32'd44));
        send_item(evidence(13'd4096, 13'd4095, ALL_FLAGS, 32'd45));
        drain();
        for (i = 0; i < 8; i++)
            write_reg(egag_pkg::cfg_idx_t'(i), REG_DEFAULTS[i]);
        // longest dwell: promotion on the 255th newer item
        write_reg(egag_pkg::REG_DWELL_NEEDED, 13'd255);
        gap_max    = 6;
        stall_mode = STALL_LIGHT;
        send_item(init_item(2'd0, 32'd1000));
        for (i = 0; i < 258; i++)
            send_item(evidence(egag_pkg::FIX_BITS'($urandom_range(0, 1229)),
                               egag_pkg::FIX_BITS'($urandom_range(3277, 4096)), ALL_FLAGS,
                               32'd1001 + i));
        drain();
        write_reg(egag_pkg::REG_DWELL_NEEDED, REG_DEFAULTS[egag_pkg::REG_DWELL_NEEDED]);
        gap_max    = 0;
        stall_mode = STALL_NONE;
    endtask

    // Receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        int i;
        gap_max    = 0;
        stall_mode = STALL_NONE;
        write_reg(egag_pkg::REG_DWELL_NEEDED, 13'd2);
        send_item(init_item(2'd1, 32'd5000));
        hold_request = 200;
        for (i = 0; i < 60; i++)
            send_item(well_formed(70));
        drain();
    endtask

    function automatic logic [egag_pkg::CFG_DATA_BITS-1:0] rand_threshold(
        input egag_pkg::cfg_idx_t idx);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return egag_pkg::FIX_ONE;
            2:       return '1;
            3, 4, 5: return REG_DEFAULTS[idx];
            default: return egag_pkg::CFG_DATA_BITS'($urandom_range(0, 4096));
        endcase
    endfunction

    // Random phases: fresh settings, pacing and a stream of mostly valid evidence
    task automatic test_random();
        int                 phase;
        int                 i;
        int                 r;
        int                 strong_pct;
        egag_pkg::cfg_idx_t idx;
        for (phase = 0; phase < 10; phase++)
        begin
            for (i = 0; i < 6; i++)
            begin
                idx = egag_pkg::cfg_idx_t'(i);
                write_reg(idx, rand_threshold(idx));
            end
            r = $urandom_range(0, 5);
            write_reg(egag_pkg::REG_DWELL_NEEDED,
                      (r == 0) ? 13'd0 : {5'($urandom), 8'($urandom_range(1, 4))});
            write_reg(egag_pkg::REG_LEVEL_CEILING, {11'($urandom), 2'($urandom)});
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 2;
                2:       gap_max = 6;
                default: gap_max = 20;
            endcase
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            strong_pct = $urandom_range(40, 90);
            if ($urandom_range(0, 9) != 0)
                send_item(init_item(2'($urandom),
                                    ($urandom_range(0, 9) == 0) ? $urandom
                                                                : $urandom_range(0, 1 << 30)));
            for (i = 0; i < 45; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    send_item(init_item(2'($urandom), $urandom_range(0, 1 << 30)));
                else if (r < 15)
                    send_item(noise_item());
                else
                    send_item(well_formed(strong_pct));
            end
            drain();
        end
        gap_max    = 0;
        stall_mode = STALL_NONE;
    endtask

    initial
    begin
        int i;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        func          = egag_pkg::FUNC_EVIDENCE;
        start_level   = '0;
        risk_bound    = '0;
        agreement     = '0;
        is_fresh      = 1'b0;
        provenance_ok = 1'b0;
        witness_ok    = 1'b0;
        anchor_ok     = 1'b0;
        epoch         = '0;
        for (i = 0; i < 8; i++)
            reg_shadow[i] = REG_DEFAULTS[i];
        auth_level     = '0;
        dwell_ctr      = '0;
        last_ep        = '0;
        governor_ready = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_before_init();
        test_directed();
        test_config_edges();
        test_backpressure();
        test_random();
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/egag_pkg.sv
hw/rtl/egag_front.sv
hw/rtl/egag_queue.sv
hw/rtl/egag_back.sv
hw/rtl/evidence_gated_authority_governor_core.sv
dv/evidence_gated_authority_governor_core_tb.sv
